// ===== src/coib_pkg.sv =====
// coib_pkg: shared types and constants of the coalescing input event buffer
// slot entry layout, beat widths and sequencer states; no dependencies
package coib_pkg;

  localparam int ID_W    = 8;
  localparam int KIND_W  = 4;
  localparam int VALUE_W = 16;
  localparam int ENTRY_W = ID_W + KIND_W + 2 * VALUE_W;
  localparam int DATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTARY   = 2'd2;

  // packed with id in the lowest bits
  typedef struct packed {
    logic signed [VALUE_W-1:0] after_val;
    logic signed [VALUE_W-1:0] before_val;
    logic        [KIND_W-1:0]  kind;
    logic        [ID_W-1:0]    id;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PSCAN,
    S_PWRITE,
    S_QSCAN,
    S_QREAD,
    S_QOUT
  } state_t;

endpackage

// ===== src/coalescing_input_event_buffer_core.sv =====
// coalescing_input_event_buffer_core: slot buffer of input events with coalescing
// slot contents in one synchronous memory, busy flags in flip-flops
// depends on coib_pkg
//
//  channel   dir  beat fields
//  s_axis    in   tuser: req_type  tdata: in_id, in_kind, in_before, in_after
//  m_axis    out  tuser: found     tdata: out_id, out_kind, out_before, out_after
//  cfg       in   cfg_index selects analog_code_a, analog_code_b, rotary_code
//
// a push runs from acceptance to the next ready as one memory read
// per slot to search for the same id, a wait for the last read data, one write-back
// a pop runs a busy-flag scan of one slot per cycle, a read and
// the load of the output register, which waits while an earlier result is held
// reset clears busy flags and pop pointer and sets the codes to 1, 2, 3 at once; no clearing pass
// input is taken while a result still waits at the output
module coalescing_input_event_buffer_core
  import coib_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,  // in_id, in_kind, in_before, in_after
  input  logic                 s_axis_tuser,  // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,  // out_id, out_kind, out_before, out_after
  output logic                 m_axis_tuser,  // found
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KIND_W-1:0]    cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);

  state_t state, state_next;

  logic [KIND_W-1:0] analog_a, analog_b, rotary;

  logic [SLOTS-1:0] busy;
  logic             ptr_valid;
  logic [IDX_W-1:0] ptr;

  entry_t mem [SLOTS];
  entry_t mem_q;
  logic   mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  entry_t mem_wdata;

  logic [CNT_W-1:0] cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;

  entry_t item;
  logic   is_analog, is_rotary;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_entry;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             first_found, next_found;
  logic [IDX_W-1:0] first_idx, next_idx;
  logic             any;
  logic [IDX_W-1:0] pick;
  logic             out_load;

  logic signed [VALUE_W-1:0] rot_sum;
  entry_t s_entry;

  assign s_entry       = entry_t'(s_axis_tdata[ENTRY_W-1:0]);
  assign s_axis_tready = (state == S_IDLE);
  assign any           = first_found | next_found;
  assign pick          = next_found ? next_idx : first_idx;
  assign rot_sum       = hit_entry.after_val + item.after_val;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = cnt[IDX_W-1:0];
    mem_we     = 1'b0;
    mem_waddr  = hit ? hit_idx : (free_found ? free_idx : '0);
    mem_wdata  = item;
    out_load   = 1'b0;
    if (hit) begin
      mem_wdata.id         = hit_entry.id;
      mem_wdata.kind       = hit_entry.kind;
      mem_wdata.before_val = is_analog ? item.before_val : hit_entry.before_val;
      mem_wdata.after_val  = is_analog ? item.after_val : rot_sum;
    end
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = s_axis_tuser ? S_QSCAN : S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (cnt != CNT_END) begin
          mem_re = 1'b1;
        end else begin
          state_next = S_PWRITE;
        end
      end
      S_PWRITE: begin
        mem_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_QSCAN: begin
        if (cnt == CNT_LAST) begin
          state_next = S_QREAD;
        end
      end
      S_QREAD: begin
        mem_re     = 1'b1;
        mem_raddr  = pick;
        state_next = S_QOUT;
      end
      S_QOUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      analog_a      <= KIND_W'(1);
      analog_b      <= KIND_W'(2);
      rotary        <= KIND_W'(3);
      busy          <= '0;
      ptr_valid     <= 1'b0;
      ptr           <= '0;
      m_axis_tvalid <= 1'b0;
      cnt           <= '0;
      rd_vld        <= 1'b0;
      hit           <= 1'b0;
      free_found    <= 1'b0;
      first_found   <= 1'b0;
      next_found    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANALOG_A: analog_a <= cfg_data;
          CFG_ANALOG_B: analog_b <= cfg_data;
          CFG_ROTARY:   rotary   <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            item        <= s_entry;
            is_analog   <= (s_entry.kind == analog_a) || (s_entry.kind == analog_b);
            is_rotary   <= (s_entry.kind != analog_a) && (s_entry.kind != analog_b) &&
                           (s_entry.kind == rotary);
            cnt         <= '0;
            rd_vld      <= 1'b0;
            hit         <= 1'b0;
            free_found  <= 1'b0;
            first_found <= 1'b0;
            next_found  <= 1'b0;
          end
        end
        S_PSCAN: begin
          rd_vld <= mem_re;
          rd_idx <= cnt[IDX_W-1:0];
          if (mem_re) begin
            cnt <= cnt + CNT_W'(1);
            if (!busy[cnt[IDX_W-1:0]] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cnt[IDX_W-1:0];
            end
          end
          // same id match, lowest slot wins
          if (rd_vld && (is_analog || is_rotary) && busy[rd_idx] &&
              (mem_q.id == item.id) && !hit) begin
            hit       <= 1'b1;
            hit_idx   <= rd_idx;
            hit_entry <= mem_q;
          end
        end
        S_PWRITE: begin
          if (!hit) begin
            busy[mem_waddr] <= 1'b1;
          end
        end
        S_QSCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (busy[cnt[IDX_W-1:0]]) begin
            if (!first_found) begin
              first_found <= 1'b1;
              first_idx   <= cnt[IDX_W-1:0];
            end
            if (ptr_valid && (cnt[IDX_W-1:0] > ptr) && !next_found) begin
              next_found <= 1'b1;
              next_idx   <= cnt[IDX_W-1:0];
            end
          end
        end
        S_QOUT: begin
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= any;
            m_axis_tdata  <= any ? DATA_W'(mem_q) : '0;
            ptr_valid     <= any;
            ptr           <= any ? pick : '0;
            if (any) begin
              busy[pick] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_pop_frees_slot: assert property (@(posedge clk) disable iff (rst)
    (out_load && any) |=> !busy[$past(pick)])
    else $error("popped slot still busy");

  a_push_fills_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_PWRITE && !hit) |=> busy[$past(mem_waddr)])
    else $error("stored slot not marked busy");

  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_QOUT))
    else $error("result raised outside a pop");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && !any) |=> (!ptr_valid && m_axis_tdata == '0))
    else $error("empty pop left pointer or data set");

endmodule

// ===== tb/testbench.sv =====
// testbench for coalescing_input_event_buffer_core: stream push and pop beats checked
// against an in-bench slot buffer model, under several code settings
// depends on coib_pkg and the core; needs nothing else
`timescale 1ns / 1ps

module testbench;
  import coib_pkg::*;

  localparam int NSLOTS = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 2 * NSLOTS + 8;

  typedef struct {
    logic   pop;
    entry_t ev;
  } request_t;

  typedef struct {
    logic   found;
    entry_t ev;
  } pop_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;  // in_id, in_kind, in_before, in_after
  logic                 s_axis_tuser = 1'b0;  // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;  // out_id, out_kind, out_before, out_after
  logic                 m_axis_tuser;  // found
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KIND_W-1:0]    cfg_data = '0;

  coalescing_input_event_buffer_core #(
    .SLOTS(NSLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model of the slot buffer
  logic        slot_used [NSLOTS] = '{default: 1'b0};
  entry_t      slot_ev [NSLOTS];
  logic        last_pop_valid = 1'b0;
  int          last_pop_slot = 0;
  logic [3:0]  code_a = 4'd1;
  logic [3:0]  code_b = 4'd2;
  logic [3:0]  code_rot = 4'd3;

  request_t    pending_beats [$];
  pop_result_t pops_due [$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  bit          holding = 1'b0;

  task automatic report_error(input string msg);
    errors++;
    $display("%0t ns: %s", $time, msg);
  endtask

  function automatic void predict_buffer(input request_t req);
    int hit;
    int pick;
    pop_result_t r;
    hit = -1;
    pick = -1;
    if (!req.pop) begin
      for (int i = 0; i < NSLOTS; i++)
        if (hit < 0 && slot_used[i] && slot_ev[i].id == req.ev.id) hit = i;
      if ((req.ev.kind == code_a || req.ev.kind == code_b) && hit >= 0) begin
        slot_ev[hit].before_val = req.ev.before_val;
        slot_ev[hit].after_val = req.ev.after_val;
      end else if (req.ev.kind == code_rot && hit >= 0) begin
        slot_ev[hit].after_val = slot_ev[hit].after_val + req.ev.after_val;
      end else begin
        for (int i = 0; i < NSLOTS; i++)
          if (pick < 0 && !slot_used[i]) pick = i;
        if (pick < 0) pick = 0;
        slot_used[pick] = 1'b1;
        slot_ev[pick] = req.ev;
      end
    end else begin
      if (last_pop_valid)
        for (int i = 0; i < NSLOTS; i++)
          if (pick < 0 && slot_used[i] && i > last_pop_slot) pick = i;
      for (int i = 0; i < NSLOTS; i++)
        if (pick < 0 && slot_used[i]) pick = i;
      if (pick < 0) begin
        last_pop_valid = 1'b0;
        last_pop_slot = 0;
        r.found = 1'b0;
        r.ev = '0;
      end else begin
        slot_used[pick] = 1'b0;
        last_pop_valid = 1'b1;
        last_pop_slot = pick;
        r.found = 1'b1;
        r.ev = slot_ev[pick];
      end
      pops_due.push_back(r);
    end
  endfunction

  function automatic void add_push(input logic [7:0] id, input logic [3:0] kind,
                                   input logic [15:0] before_v, input logic [15:0] after_v);
    request_t req;
    req.pop = 1'b0;
    req.ev.id = id;
    req.ev.kind = kind;
    req.ev.before_val = before_v;
    req.ev.after_val = after_v;
    pending_beats.push_back(req);
  endfunction

  function automatic void add_pop();
    request_t req;
    req.pop = 1'b1;
    req.ev = entry_t'($urandom() ^ {$urandom(), 12'h0});
    pending_beats.push_back(req);
  endfunction

  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void add_random(input int count, input int push_pct);
    logic [7:0] id;
    logic [3:0] kind;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(1, 100) > push_pct) begin
        add_pop();
      end else begin
        if ($urandom_range(0, 9) < 7) id = 8'($urandom_range(0, 5));
        else id = 8'($urandom());
        case ($urandom_range(0, 4))
          0: kind = code_a;
          1: kind = code_b;
          2: kind = code_rot;
          default: kind = 4'($urandom());
        endcase
        add_push(id, kind, random_value(), random_value());
      end
    end
  endfunction

  task automatic set_codes(input logic [3:0] a, input logic [3:0] b, input logic [3:0] r);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ANALOG_A;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= CFG_ANALOG_B;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= CFG_ROTARY;
    cfg_data <= r;
    // write to the unused index must leave all codes alone
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data <= 4'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
    code_a = a;
    code_b = b;
    code_rot = r;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || holding || pops_due.size() != 0);
  endtask

  // source side
  always @(posedge clk) begin : drive
    logic [DATA_W-1:0] word;
    static int src_gap = 0;
    static request_t cur;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
      holding = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_buffer(cur);
        holding = 1'b0;
      end
      if (!holding) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 7);
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          cur = pending_beats.pop_front();
          word = '0;
          word[ENTRY_W-1:0] = cur.ev;
          s_axis_tdata <= word;
          s_axis_tuser <= cur.pop;
          s_axis_tvalid <= 1'b1;
          holding = 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk) begin : watch
    entry_t got;
    pop_result_t want;
    static int sink_gap = 0;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[ENTRY_W-1:0];
        if (pops_due.size() == 0) begin
          report_error("result beat with no pop outstanding");
        end else begin
          want = pops_due.pop_front();
          if (m_axis_tuser !== want.found)
            report_error($sformatf("found %b, want %b", m_axis_tuser, want.found));
          if (got.id !== want.ev.id)
            report_error($sformatf("id %h, want %h", got.id, want.ev.id));
          if (got.kind !== want.ev.kind)
            report_error($sformatf("kind %h, want %h", got.kind, want.ev.kind));
          if (got.before_val !== want.ev.before_val)
            report_error($sformatf("before %h, want %h", got.before_val, want.ev.before_val));
          if (got.after_val !== want.ev.after_val)
            report_error($sformatf("after %h, want %h", got.after_val, want.ev.after_val));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pop, analog overwrite, rotary wrap, unmatched kinds, pointer wrap
    add_pop();
    add_push(8'h00, 4'd1, 16'h8000, 16'h7fff);
    add_push(8'h00, 4'd1, 16'h7fff, 16'h8000);
    add_push(8'hff, 4'd3, 16'h0000, 16'h7fff);
    add_push(8'hff, 4'd3, 16'hffff, 16'h0001);
    add_push(8'hff, 4'd2, 16'h1234, 16'hffff);
    add_push(8'h00, 4'd15, 16'h0000, 16'h0000);
    add_push(8'h07, 4'd3, 16'haaaa, 16'h5555);
    add_push(8'h07, 4'd1, 16'h5555, 16'haaaa);
    repeat (6) add_pop();
    add_push(8'h09, 4'd0, 16'h0001, 16'hfffe);
    add_push(8'h0a, 4'd0, 16'h00f0, 16'h0f00);
    add_pop();
    add_push(8'h0b, 4'd0, 16'hf00f, 16'h0ff0);
    repeat (2) add_pop();
    add_random(140, 60);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    set_codes(4'd0, 4'd15, 4'd7);
    @(negedge clk);
    add_random(160, 80);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // one code both analog and rotary
    set_codes(4'd5, 4'd15, 4'd5);
    @(negedge clk);
    add_random(160, 50);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    set_codes(4'd15, 4'd15, 4'd0);
    @(negedge clk);
    add_random(160, 70);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    set_codes(4'd0, 4'd0, 4'd0);
    @(negedge clk);
    add_random(160, 40);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // last part runs without gaps on either side
    set_codes(4'd1, 4'd2, 4'd3);
    @(negedge clk);
    idle_on = 1'b0;
    add_random(160, 65);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pops_due.size() != 0)
      report_error($sformatf("%0d results never arrived", pops_due.size()));
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
src/coib_pkg.sv
src/coalescing_input_event_buffer_core.sv
tb/testbench.sv
